// File: rtl/core/hack_instruction_line_encoder_defines.svh
// Assertion macros for the Hack line encoder.
// Both expect a signal named clk, and HILE_ASSERT also arst_n, in the scope of use.
`ifndef HACK_INSTRUCTION_LINE_ENCODER_DEFINES_SVH
`define HACK_INSTRUCTION_LINE_ENCODER_DEFINES_SVH

// Checked outside reset only
`define HILE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Checked at every edge, reset included
`define HILE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/hile_pkg.sv
package hile_pkg;

	localparam int TOK_CHARS = 3;
	localparam int LEN_W     = 3;
	localparam int ADDR_W    = 15;
	localparam int WORD_W    = 16;
	localparam int STATUS_W  = 3;
	localparam int COMP_W    = 7;
	localparam int JUMP_W    = 3;

	typedef logic [7:0] char_t;

	// Line classification
	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_A,
		CLS_LABEL,
		CLS_C
	} cls_t;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_AWORD    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_CWORD    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LABEL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SYMBOL   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SYNTAX   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BAD_COMP = 3'd5;
	localparam logic [STATUS_W-1:0] ST_BAD_DEST = 3'd6;
	localparam logic [STATUS_W-1:0] ST_BAD_JUMP = 3'd7;

	// Operand progress of an A-instruction
	localparam logic [1:0] AF_NONE   = 2'd0;
	localparam logic [1:0] AF_DIGITS = 2'd1;
	localparam logic [1:0] AF_ENDED  = 2'd2;
	localparam logic [1:0] AF_SYMBOL = 2'd3;

	// Label closing state
	localparam logic [1:0] LBL_OPEN   = 2'd0;
	localparam logic [1:0] LBL_CLOSED = 2'd1;

	// Token slots of a C-instruction
	localparam logic [1:0] TOK_DEST = 2'd0;
	localparam logic [1:0] TOK_COMP = 2'd1;
	localparam logic [1:0] TOK_JUMP = 2'd2;

	// Characters of interest
	localparam char_t CH_TAB    = 8'h09;
	localparam char_t CH_LF     = 8'h0A;
	localparam char_t CH_CR     = 8'h0D;
	localparam char_t CH_SPACE  = 8'h20;
	localparam char_t CH_LPAREN = 8'h28;
	localparam char_t CH_RPAREN = 8'h29;
	localparam char_t CH_SLASH  = 8'h2F;
	localparam char_t CH_ZERO   = 8'h30;
	localparam char_t CH_NINE   = 8'h39;
	localparam char_t CH_SEMI   = 8'h3B;
	localparam char_t CH_EQ     = 8'h3D;
	localparam char_t CH_AT     = 8'h40;
	localparam char_t CH_A      = 8'h41;
	localparam char_t CH_D      = 8'h44;
	localparam char_t CH_M      = 8'h4D;

	// Per-line parse state
	typedef struct packed {
		cls_t                             cls;
		logic                             cmt_pend;
		logic                             in_cmt;
		logic                             eq_seen;
		logic                             semi_seen;
		logic                             syn_err;
		char_t [TOK_CHARS-1:0][TOK_CHARS-1:0] tok;
		logic [TOK_CHARS-1:0][LEN_W-1:0]  len;
		logic [3:0]                       dest_bits;
		logic [ADDR_W-1:0]                addr;
		logic [1:0]                       aflags;
	} line_t;

	// Encoded result of one line
	typedef struct packed {
		logic                emit;
		logic [WORD_W-1:0]   word;
		logic [STATUS_W-1:0] status;
	} res_t;

	typedef struct packed {
		logic              hit;
		logic [COMP_W-1:0] code;
	} comp_res_t;

	typedef struct packed {
		logic              hit;
		logic [JUMP_W-1:0] code;
	} jump_res_t;

	// Comp mnemonic table; unused character places are keyed as zero
	function automatic comp_res_t comp_lookup(char_t [TOK_CHARS-1:0] t,
			logic [LEN_W-1:0] n);
		comp_res_t  r;
		logic [25:0] key;
		key = {n[1:0], t[0], (n >= 3'd2) ? t[1] : 8'h00,
			(n >= 3'd3) ? t[2] : 8'h00};
		r.hit = (n <= 3'd3) && (n != 3'd0);
		case (key)
			{2'd1, "0", 16'h0000}: r.code = 7'h2A;
			{2'd1, "1", 16'h0000}: r.code = 7'h3F;
			{2'd2, "-1", 8'h00}:   r.code = 7'h3A;
			{2'd1, "D", 16'h0000}: r.code = 7'h0C;
			{2'd2, "!D", 8'h00}:   r.code = 7'h0D;
			{2'd2, "-D", 8'h00}:   r.code = 7'h0F;
			{2'd3, "D+1"}:         r.code = 7'h1F;
			{2'd3, "1+D"}:         r.code = 7'h1F;
			{2'd3, "D-1"}:         r.code = 7'h0E;
			{2'd1, "A", 16'h0000}: r.code = 7'h30;
			{2'd1, "M", 16'h0000}: r.code = 7'h70;
			{2'd2, "!A", 8'h00}:   r.code = 7'h31;
			{2'd2, "!M", 8'h00}:   r.code = 7'h71;
			{2'd2, "-A", 8'h00}:   r.code = 7'h33;
			{2'd2, "-M", 8'h00}:   r.code = 7'h73;
			{2'd3, "A+1"}:         r.code = 7'h37;
			{2'd3, "1+A"}:         r.code = 7'h37;
			{2'd3, "M+1"}:         r.code = 7'h77;
			{2'd3, "1+M"}:         r.code = 7'h77;
			{2'd3, "A-1"}:         r.code = 7'h32;
			{2'd3, "M-1"}:         r.code = 7'h72;
			{2'd3, "D+A"}:         r.code = 7'h02;
			{2'd3, "A+D"}:         r.code = 7'h02;
			{2'd3, "D+M"}:         r.code = 7'h42;
			{2'd3, "M+D"}:         r.code = 7'h42;
			{2'd3, "D-A"}:         r.code = 7'h13;
			{2'd3, "D-M"}:         r.code = 7'h53;
			{2'd3, "A-D"}:         r.code = 7'h07;
			{2'd3, "M-D"}:         r.code = 7'h47;
			{2'd3, "D&A"}:         r.code = 7'h00;
			{2'd3, "A&D"}:         r.code = 7'h00;
			{2'd3, "D&M"}:         r.code = 7'h40;
			{2'd3, "M&D"}:         r.code = 7'h40;
			{2'd3, "D|A"}:         r.code = 7'h15;
			{2'd3, "A|D"}:         r.code = 7'h15;
			{2'd3, "D|M"}:         r.code = 7'h55;
			{2'd3, "M|D"}:         r.code = 7'h55;
			default: begin
				r.hit  = 1'b0;
				r.code = '0;
			end
		endcase
		return r;
	endfunction

	// Jump mnemonics are all three characters long
	function automatic jump_res_t jump_lookup(char_t [TOK_CHARS-1:0] t,
			logic [LEN_W-1:0] n);
		jump_res_t r;
		r.hit = (n == 3'd3);
		case ({t[0], t[1], t[2]})
			"JGT":   r.code = 3'd1;
			"JEQ":   r.code = 3'd2;
			"JGE":   r.code = 3'd3;
			"JLT":   r.code = 3'd4;
			"JNE":   r.code = 3'd5;
			"JLE":   r.code = 3'd6;
			"JMP":   r.code = 3'd7;
			default: begin
				r.hit  = 1'b0;
				r.code = '0;
			end
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/hile_line.sv
// Character scanner: keeps the parse state of the current line.
module hile_line (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic             kind,
	input  hile_pkg::char_t  ch,
	output hile_pkg::line_t  eol_line
);

	hile_pkg::line_t line_q;
	hile_pkg::line_t pend_clr;
	hile_pkg::line_t feed_nxt;

	// Add one character to a token, keeping the first three
	function automatic hile_pkg::line_t tok_append(hile_pkg::line_t s,
			logic [1:0] slot, hile_pkg::char_t c);
		hile_pkg::line_t r;
		r = s;
		for (int k = 0; k < hile_pkg::TOK_CHARS; k++) begin
			if (s.len[slot] == hile_pkg::LEN_W'(k))
				r.tok[slot][k] = c;
		end
		if (s.len[slot] != '1)
			r.len[slot] = s.len[slot] + 1'b1;
		return r;
	endfunction

	// C-instruction splitting on '=' and ';'
	function automatic hile_pkg::line_t c_char(hile_pkg::line_t s,
			hile_pkg::char_t c);
		hile_pkg::line_t r;
		r = s;
		if (c == hile_pkg::CH_SPACE || c == hile_pkg::CH_TAB || s.syn_err) begin
			r = s;
		end else if (c == hile_pkg::CH_EQ) begin
			if (s.eq_seen)
				r.syn_err = 1'b1;
			else
				r.eq_seen = 1'b1;
		end else if (c == hile_pkg::CH_SEMI) begin
			if (s.semi_seen) begin
				r.syn_err = 1'b1;
			end else begin
				r.eq_seen = 1'b1;
				// no comp yet: the first token was the comp
				if (s.len[hile_pkg::TOK_COMP] == '0) begin
					r.tok[hile_pkg::TOK_COMP] = s.tok[hile_pkg::TOK_DEST];
					r.len[hile_pkg::TOK_COMP] = s.len[hile_pkg::TOK_DEST];
					r.len[hile_pkg::TOK_DEST] = '0;
					r.dest_bits               = '0;
				end
				r.semi_seen = 1'b1;
			end
		end else if (s.semi_seen) begin
			r = tok_append(s, hile_pkg::TOK_JUMP, c);
		end else if (s.eq_seen) begin
			r = tok_append(s, hile_pkg::TOK_COMP, c);
		end else begin
			r = tok_append(s, hile_pkg::TOK_DEST, c);
			if (c == hile_pkg::CH_A)
				r.dest_bits[2] = 1'b1;
			else if (c == hile_pkg::CH_D)
				r.dest_bits[1] = 1'b1;
			else if (c == hile_pkg::CH_M)
				r.dest_bits[0] = 1'b1;
			else
				r.dest_bits[3] = 1'b1;
		end
		return r;
	endfunction

	// One useful character of the line
	function automatic hile_pkg::line_t line_char(hile_pkg::line_t s,
			hile_pkg::char_t c);
		hile_pkg::line_t r;
		logic            blank;
		logic            digit;
		r     = s;
		blank = (c == hile_pkg::CH_SPACE) || (c == hile_pkg::CH_TAB);
		digit = (c >= hile_pkg::CH_ZERO) && (c <= hile_pkg::CH_NINE);
		case (s.cls)
			hile_pkg::CLS_NONE: begin
				if (!blank) begin
					if (c == hile_pkg::CH_AT) begin
						r.cls = hile_pkg::CLS_A;
					end else if (c == hile_pkg::CH_LPAREN) begin
						r.cls = hile_pkg::CLS_LABEL;
					end else begin
						r.cls = hile_pkg::CLS_C;
						r     = c_char(r, c);
					end
				end
			end
			hile_pkg::CLS_A: begin
				if (s.aflags == hile_pkg::AF_NONE) begin
					if (digit) begin
						r.addr   = hile_pkg::ADDR_W'(c[3:0]);
						r.aflags = hile_pkg::AF_DIGITS;
					end else begin
						r.aflags = hile_pkg::AF_SYMBOL;
					end
				end else if (s.aflags == hile_pkg::AF_DIGITS) begin
					// times ten by shifts, wrapping to the address width
					if (digit)
						r.addr = (s.addr << 3) + (s.addr << 1)
							+ hile_pkg::ADDR_W'(c[3:0]);
					else
						r.aflags = hile_pkg::AF_ENDED;
				end
			end
			hile_pkg::CLS_LABEL: begin
				if (!blank)
					r.aflags = (c == hile_pkg::CH_RPAREN) ? hile_pkg::LBL_CLOSED
						: hile_pkg::LBL_OPEN;
			end
			hile_pkg::CLS_C: begin
				r = c_char(s, c);
			end
			default: begin
				r = s;
			end
		endcase
		return r;
	endfunction

	// Comment and line-break filtering; a held '/' goes out ahead of c
	function automatic hile_pkg::line_t feed(hile_pkg::line_t s,
			hile_pkg::char_t c);
		hile_pkg::line_t r;
		r = s;
		if (c == hile_pkg::CH_CR || c == hile_pkg::CH_LF || s.in_cmt) begin
			r = s;
		end else if (s.cmt_pend) begin
			r.cmt_pend = 1'b0;
			if (c == hile_pkg::CH_SLASH)
				r.in_cmt = 1'b1;
			else
				r = line_char(line_char(r, hile_pkg::CH_SLASH), c);
		end else if (c == hile_pkg::CH_SLASH) begin
			r.cmt_pend = 1'b1;
		end else begin
			r = line_char(s, c);
		end
		return r;
	endfunction

	// Line state as seen at end of line: a held '/' counts as a character
	always_comb begin
		pend_clr          = line_q;
		pend_clr.cmt_pend = 1'b0;
		if (line_q.cmt_pend)
			eol_line = line_char(pend_clr, hile_pkg::CH_SLASH);
		else
			eol_line = line_q;
	end

	assign feed_nxt = feed(line_q, ch);

	// State update; end of line starts a fresh line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
		end else if (go) begin
			if (kind)
				line_q <= '0;
			else
				line_q <= feed_nxt;
		end
	end

endmodule

// File: rtl/core/hile_encode.sv
// End-of-line encoder: classifies the line and builds the machine word.
module hile_encode (
	input  hile_pkg::line_t line_st,
	output hile_pkg::res_t  res
);

	hile_pkg::comp_res_t comp_r;
	hile_pkg::jump_res_t jump_r;
	logic                d_any;
	logic                c_any;
	logic                j_any;
	logic                syntax_bad;

	assign comp_r = hile_pkg::comp_lookup(line_st.tok[hile_pkg::TOK_COMP],
		line_st.len[hile_pkg::TOK_COMP]);
	assign jump_r = hile_pkg::jump_lookup(line_st.tok[hile_pkg::TOK_JUMP],
		line_st.len[hile_pkg::TOK_JUMP]);

	assign d_any = (line_st.len[hile_pkg::TOK_DEST] != '0);
	assign c_any = (line_st.len[hile_pkg::TOK_COMP] != '0);
	assign j_any = (line_st.len[hile_pkg::TOK_JUMP] != '0);

	// Malformed split: dest alone, ';' with no jump, '=' with no comp
	assign syntax_bad = line_st.syn_err || (d_any && !c_any && !j_any)
		|| (!j_any && line_st.semi_seen) || (!c_any && line_st.eq_seen);

	// Field checks in order comp, dest, jump
	always_comb begin
		res.emit   = 1'b1;
		res.word   = '0;
		res.status = hile_pkg::ST_SYNTAX;
		case (line_st.cls)
			hile_pkg::CLS_NONE: begin
				res.emit = 1'b0;
			end
			hile_pkg::CLS_A: begin
				if (line_st.aflags == hile_pkg::AF_NONE
						|| line_st.aflags == hile_pkg::AF_SYMBOL) begin
					res.status = hile_pkg::ST_SYMBOL;
				end else begin
					res.word   = hile_pkg::WORD_W'(line_st.addr);
					res.status = hile_pkg::ST_AWORD;
				end
			end
			hile_pkg::CLS_LABEL: begin
				res.status = line_st.aflags[0] ? hile_pkg::ST_LABEL
					: hile_pkg::ST_SYNTAX;
			end
			hile_pkg::CLS_C: begin
				if (syntax_bad) begin
					res.status = hile_pkg::ST_SYNTAX;
				end else if (c_any && !comp_r.hit) begin
					res.status = hile_pkg::ST_BAD_COMP;
				end else if (d_any && line_st.dest_bits[3]) begin
					res.status = hile_pkg::ST_BAD_DEST;
				end else if (j_any && !jump_r.hit) begin
					res.status = hile_pkg::ST_BAD_JUMP;
				end else begin
					res.word = {3'b111,
						c_any ? comp_r.code : {hile_pkg::COMP_W{1'b0}},
						line_st.dest_bits[2:0],
						j_any ? jump_r.code : {hile_pkg::JUMP_W{1'b0}}};
					res.status = hile_pkg::ST_CWORD;
				end
			end
			default: begin
				res.emit = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/core/hack_instruction_line_encoder.sv
// Hack assembly line encoder. Source characters (kind 0) and an end-of-line
// marker (kind 1) stream in at one request per cycle, with no gaps needed
// between lines. Characters only update the line's parse state; at end of
// line the marker passes the input register, and one result of word and
// status is loaded into the result register (later while an earlier result
// is still stalled), unless the line was empty or held only blanks and a
// comment, in which case nothing comes out. Each request passes one input
// register and then the combinational scan or encode logic into the result
// register, so the sustained rate is one request per cycle. A stalled result
// holds up an end-of-line marker in the input register, and with it every
// request behind it; characters on their own never wait. Status 0 and 1
// carry a valid word; for the error and label codes the word reads as zero.
module hack_instruction_line_encoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [7:0]                        ch,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [hile_pkg::WORD_W-1:0]       word,
	output logic [hile_pkg::STATUS_W-1:0]     status
);

	logic                            valid_s1;
	logic                            kind_s1;
	hile_pkg::char_t                 ch_s1;
	logic                            go;
	hile_pkg::line_t                 eol_line;
	hile_pkg::res_t                  res;
	logic                            out_valid_q;
	logic [hile_pkg::WORD_W-1:0]     word_q;
	logic [hile_pkg::STATUS_W-1:0]   status_q;

	// Characters always proceed; end of line needs room in the result register
	assign go       = valid_s1 && (!kind_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || go) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			ch_s1   <= ch;
		end
	end

	hile_line u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.kind     (kind_s1),
		.ch       (ch_s1),
		.eol_line (eol_line)
	);

	hile_encode u_enc (
		.line_st (eol_line),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && kind_s1) begin
			out_valid_q <= res.emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && kind_s1 && res.emit) begin
			word_q   <= res.word;
			status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign word      = word_q;
	assign status    = status_q;

endmodule

// File: rtl/core/hile_checker.sv
`include "hack_instruction_line_encoder_defines.svh"

// Port-level checks for the line encoder
module hile_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            kind,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [hile_pkg::WORD_W-1:0]     word,
	input logic [hile_pkg::STATUS_W-1:0]   status
);

	// A stalled result keeps its payload
	`HILE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(word) && $stable(status), "result changed while stalled")

	// Error and label results carry a zero word
	`HILE_ASSERT(a_err_word_zero, out_valid && status != hile_pkg::ST_AWORD && status != hile_pkg::ST_CWORD |-> word == '0, "non-zero word on error or label")

	// Word format follows the class
	`HILE_ASSERT(a_word_form, out_valid && (status == hile_pkg::ST_AWORD || status == hile_pkg::ST_CWORD) |-> word[15] == (status == hile_pkg::ST_CWORD) && (status == hile_pkg::ST_AWORD || word[14:13] == 2'b11), "malformed instruction word")

	// A fresh result follows the taking of an end-of-line request
	`HILE_ASSERT(a_result_cause, out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall && kind, 2), "result without end of line")

	// Nothing is offered while in reset
	`HILE_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "result during reset")

endmodule

bind hack_instruction_line_encoder hile_checker u_hile_checker (.*);

// File: test/line_encode_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the line encoder, keeps its own model of the line
// parser and checks every result against the oldest one still awaited.
module line_encode_checker
	import hile_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                kind,
	input  char_t               ch,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [WORD_W-1:0]   word,
	input  logic [STATUS_W-1:0] status,
	output int                  errors,
	output int                  pending
);

	localparam logic KIND_EOL = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0]   word;
		logic [STATUS_W-1:0] status;
	} line_result_t;

	line_result_t awaited[$];
	int err_count  = 0;
	int wait_count = 0;

	// line parse state
	cls_t              cls;
	logic              cmt_pend;
	logic              in_cmt;
	logic              eq_seen;
	logic              semi_seen;
	logic              split_bad;
	char_t [2:0]       tok [3];
	logic [LEN_W-1:0]  tlen [3];
	logic [3:0]        dbits;
	logic [ADDR_W-1:0] addr;
	logic [1:0]        aflags;

	assign errors  = err_count;
	assign pending = wait_count;

	function void clear_line();
		cls       = CLS_NONE;
		cmt_pend  = 1'b0;
		in_cmt    = 1'b0;
		eq_seen   = 1'b0;
		semi_seen = 1'b0;
		split_bad = 1'b0;
		for (int s = 0; s < 3; s++) begin
			tok[s]  = '0;
			tlen[s] = '0;
		end
		dbits  = '0;
		addr   = '0;
		aflags = AF_NONE;
	endfunction

	// first three chars kept, length saturates at 7
	function void add_char(input int slot, input char_t c);
		if (tlen[slot] < 3)
			tok[slot][tlen[slot]] = c;
		if (tlen[slot] < 7)
			tlen[slot] = tlen[slot] + 1'b1;
	endfunction

	// dest=comp;jump splitting, blanks ignored
	function void split_char(input char_t c);
		if (c == CH_SPACE || c == CH_TAB || split_bad)
			return;
		if (c == CH_EQ) begin
			if (eq_seen)
				split_bad = 1'b1;
			else
				eq_seen = 1'b1;
		end else if (c == CH_SEMI) begin
			if (semi_seen) begin
				split_bad = 1'b1;
			end else begin
				eq_seen = 1'b1;
				// nothing in comp yet: the first token was the comp
				if (tlen[TOK_COMP] == 0) begin
					tok[TOK_COMP]  = tok[TOK_DEST];
					tlen[TOK_COMP] = tlen[TOK_DEST];
					tlen[TOK_DEST] = '0;
					dbits          = '0;
				end
				semi_seen = 1'b1;
			end
		end else if (semi_seen) begin
			add_char(TOK_JUMP, c);
		end else if (eq_seen) begin
			add_char(TOK_COMP, c);
		end else begin
			add_char(TOK_DEST, c);
			case (c)
				CH_A:    dbits[2] = 1'b1;
				CH_D:    dbits[1] = 1'b1;
				CH_M:    dbits[0] = 1'b1;
				default: dbits[3] = 1'b1;
			endcase
		end
	endfunction

	function void scan_char(input char_t c);
		logic blank;
		logic is_digit;
		int   acc;
		blank    = (c == CH_SPACE) || (c == CH_TAB);
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		case (cls)
			CLS_NONE: begin
				if (!blank) begin
					if (c == CH_AT)
						cls = CLS_A;
					else if (c == CH_LPAREN)
						cls = CLS_LABEL;
					else begin
						cls = CLS_C;
						split_char(c);
					end
				end
			end
			// blanks count after '@'
			CLS_A: begin
				if (aflags == AF_NONE) begin
					if (is_digit) begin
						acc    = c - CH_ZERO;
						addr   = acc[ADDR_W-1:0];
						aflags = AF_DIGITS;
					end else
						aflags = AF_SYMBOL;
				end else if (aflags == AF_DIGITS) begin
					if (is_digit) begin
						acc  = addr * 10 + (c - CH_ZERO);
						addr = acc[ADDR_W-1:0];
					end else
						aflags = AF_ENDED;
				end
			end
			CLS_LABEL: begin
				if (!blank)
					aflags = (c == CH_RPAREN) ? LBL_CLOSED : LBL_OPEN;
			end
			default: split_char(c);
		endcase
	endfunction

	// line breaks dropped, "//" starts a comment, a lone '/' is kept
	function void take_char(input char_t c);
		if (c == CH_CR || c == CH_LF || in_cmt)
			return;
		if (cmt_pend) begin
			cmt_pend = 1'b0;
			if (c == CH_SLASH)
				in_cmt = 1'b1;
			else begin
				scan_char(CH_SLASH);
				scan_char(c);
			end
		end else if (c == CH_SLASH)
			cmt_pend = 1'b1;
		else
			scan_char(c);
	endfunction

	// -1 when the mnemonic is unknown
	function automatic int comp_code(input char_t [2:0] t, input logic [LEN_W-1:0] n);
		int r;
		r = -1;
		case (n)
			3'd1: case (t[0])
				"0": r = 'h2A;
				"1": r = 'h3F;
				"D": r = 'h0C;
				"A": r = 'h30;
				"M": r = 'h70;
				default: ;
			endcase
			3'd2: case ({t[0], t[1]})
				"-1": r = 'h3A;
				"!D": r = 'h0D;
				"-D": r = 'h0F;
				"!A": r = 'h31;
				"!M": r = 'h71;
				"-A": r = 'h33;
				"-M": r = 'h73;
				default: ;
			endcase
			3'd3: case ({t[0], t[1], t[2]})
				"D+1", "1+D": r = 'h1F;
				"D-1":        r = 'h0E;
				"A+1", "1+A": r = 'h37;
				"M+1", "1+M": r = 'h77;
				"A-1":        r = 'h32;
				"M-1":        r = 'h72;
				"D+A", "A+D": r = 'h02;
				"D+M", "M+D": r = 'h42;
				"D-A":        r = 'h13;
				"D-M":        r = 'h53;
				"A-D":        r = 'h07;
				"M-D":        r = 'h47;
				"D&A", "A&D": r = 'h00;
				"D&M", "M&D": r = 'h40;
				"D|A", "A|D": r = 'h15;
				"D|M", "M|D": r = 'h55;
				default: ;
			endcase
			default: ;
		endcase
		return r;
	endfunction

	function automatic int jump_code(input char_t [2:0] t, input logic [LEN_W-1:0] n);
		int r;
		r = -1;
		if (n == 3'd3) begin
			case ({t[0], t[1], t[2]})
				"JGT": r = 1;
				"JEQ": r = 2;
				"JGE": r = 3;
				"JLT": r = 4;
				"JNE": r = 5;
				"JLE": r = 6;
				"JMP": r = 7;
				default: ;
			endcase
		end
		return r;
	endfunction

	// end of line: returns 1 when the line gives a result
	function bit close_line(output line_result_t r);
		bit emit;
		int cc;
		int jc;
		emit     = 1'b1;
		r.word   = '0;
		r.status = ST_SYNTAX;
		cc       = 0;
		jc       = 0;
		if (cmt_pend) begin
			cmt_pend = 1'b0;
			scan_char(CH_SLASH);
		end
		case (cls)
			CLS_NONE: emit = 1'b0;
			CLS_A: begin
				if (aflags == AF_NONE || aflags == AF_SYMBOL)
					r.status = ST_SYMBOL;
				else begin
					r.word   = {1'b0, addr};
					r.status = ST_AWORD;
				end
			end
			CLS_LABEL: r.status = aflags[0] ? ST_LABEL : ST_SYNTAX;
			default: begin
				if (split_bad
						|| (tlen[TOK_DEST] != 0 && tlen[TOK_COMP] == 0 && tlen[TOK_JUMP] == 0)
						|| (tlen[TOK_JUMP] == 0 && semi_seen)
						|| (tlen[TOK_COMP] == 0 && eq_seen))
					r.status = ST_SYNTAX;
				else begin
					// comp first, then dest, then jump
					if (tlen[TOK_COMP] != 0)
						cc = comp_code(tok[TOK_COMP], tlen[TOK_COMP]);
					if (cc < 0)
						r.status = ST_BAD_COMP;
					else if (tlen[TOK_DEST] != 0 && dbits[3])
						r.status = ST_BAD_DEST;
					else begin
						if (tlen[TOK_JUMP] != 0)
							jc = jump_code(tok[TOK_JUMP], tlen[TOK_JUMP]);
						if (jc < 0)
							r.status = ST_BAD_JUMP;
						else begin
							r.word   = {3'b111, cc[6:0], dbits[2:0], jc[2:0]};
							r.status = ST_CWORD;
						end
					end
				end
			end
		endcase
		clear_line();
		return emit;
	endfunction

	// compare results, then update the model with the accepted request
	always @(posedge clk or negedge arst_n) begin
		line_result_t want;
		line_result_t fresh;
		if (!arst_n) begin
			clear_line();
			awaited.delete();
			wait_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result, word %h status %0d", $time, word, status);
				end else begin
					want = awaited.pop_front();
					if (word !== want.word) begin
						err_count++;
						$display("%0t: word mismatch, expected %h actual %h", $time,
							want.word, word);
					end
					if (status !== want.status) begin
						err_count++;
						$display("%0t: status mismatch, expected %0d actual %0d", $time,
							want.status, status);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (kind == KIND_EOL) begin
					if (close_line(fresh))
						awaited.push_back(fresh);
				end else
					take_char(ch);
			end
			wait_count = awaited.size();
		end
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import hile_pkg::*;

	localparam logic KIND_CHAR   = 1'b0;
	localparam logic KIND_EOL    = 1'b1;
	localparam int   RANDOM_ITEMS = 490;
	localparam int   CALM_ITEMS   = 120;
	localparam int   HOLD_CYCLES  = 300;
	localparam int   IDLE_LIMIT   = 2000;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                kind      = KIND_CHAR;
	char_t               ch        = '0;
	logic                out_stall = 1'b0;
	logic                in_stall;
	logic                out_valid;
	logic [WORD_W-1:0]   word;
	logic [STATUS_W-1:0] status;

	int errors;
	int pending;
	int sent     = 0;
	bit tx_gaps  = 1'b1;
	bit rx_gaps  = 1'b1;
	bit hold_req = 1'b0;

	string comp_ops[$] = '{"0", "1", "-1", "D", "!D", "-D", "D+1", "1+D", "D-1",
		"A", "M", "!A", "!M", "-A", "-M", "A+1", "1+A", "M+1", "1+M", "A-1", "M-1",
		"D+A", "A+D", "D+M", "M+D", "D-A", "D-M", "A-D", "M-D",
		"D&A", "A&D", "D&M", "M&D", "D|A", "A|D", "D|M", "M|D"};
	string jump_ops[$]   = '{"JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};
	string bad_comps[$]  = '{"A&M", "A|M", "D+2", "-0", "DM+1", "1-D"};
	string bad_jumps[$]  = '{"JXX", "JM", "JMPP"};
	string dest_forms[$] = '{"M", "D", "MD", "A", "AM", "AD", "AMD"};

	// edge cases of each line class
	string directed_lines[$] = '{
		"@0", "@32767", "@99999", "@", "@R2", "@12 x", "@ 5",
		"(LOOP)", " ( END ) // ret", "(BAD)x", "(OPEN",
		"", " \t// comment only",
		"\r\nD=M\r", "AMD=D+1;JMP", "0;JMP", "D;JGT",
		"M=A&M", "D=A|M", "MD=1+D", "X=D", "D;JXX",
		"D=M;", "=D", "D", "A=D=M", "D=M/2", "D=D/", "D=D+1M"};

	hack_instruction_line_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.ch        (ch),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.word      (word),
		.status    (status)
	);

	line_encode_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.ch        (ch),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.word      (word),
		.status    (status),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side: random stall bursts, plus one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ends the run when nothing moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	function automatic string one_of(input string set);
		int k;
		k = $urandom_range(0, set.len() - 1);
		return set.substr(k, k);
	endfunction

	function automatic string blank();
		case ($urandom_range(0, 5))
			0:       return " ";
			1:       return "\t";
			2:       return " \t";
			default: return "";
		endcase
	endfunction

	// scatter blanks through a line
	function automatic string spread(input string s);
		string r;
		r = "";
		for (int i = 0; i < s.len(); i++) begin
			if ($urandom_range(0, 4) == 0)
				r = {r, blank()};
			r = {r, s.substr(i, i)};
		end
		return r;
	endfunction

	task automatic send_item(input logic k, input char_t c);
		in_valid <= 1'b1;
		kind     <= k;
		ch       <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		if (tx_gaps && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic send_line(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(KIND_CHAR, s[i]);
		send_item(KIND_EOL, char_t'($urandom));
	endtask

	// stop offering and wait until every awaited result is out; one edge
	// first so that the checker has counted the last request taken
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	task automatic random_line();
		string body;
		string dest;
		string tail;
		string pick;
		int    n;
		body = "";
		dest = "";
		tail = "";
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8: begin
				if ($urandom_range(0, 2) != 0) begin
					n = $urandom_range(1, 3);
					repeat (n) dest = {dest, one_of("AMD")};
					if ($urandom_range(0, 9) == 0)
						dest = {dest, one_of("XBm0")};
				end
				if ($urandom_range(0, 7) == 0)
					body = bad_comps[$urandom_range(0, bad_comps.size() - 1)];
				else
					body = comp_ops[$urandom_range(0, comp_ops.size() - 1)];
				if (dest.len() > 0)
					body = {dest, "=", body};
				if ($urandom_range(0, 7) < ((dest.len() > 0) ? 3 : 7)) begin
					if ($urandom_range(0, 7) == 0)
						body = {body, ";", bad_jumps[$urandom_range(0, bad_jumps.size() - 1)]};
					else
						body = {body, ";", jump_ops[$urandom_range(0, jump_ops.size() - 1)]};
				end
				// broken split: a stray '=' or ';'
				if ($urandom_range(0, 7) == 0) begin
					n    = $urandom_range(0, body.len());
					body = {body.substr(0, n - 1), one_of("=;"), body.substr(n, body.len() - 1)};
				end
				body = {blank(), spread(body)};
			end
			9, 10, 11, 12: begin
				case ($urandom_range(0, 5))
					0:       body = {"@", one_of("LRisx"), one_of("0P1")};
					1:       body = "@";
					2:       body = {"@", blank(), $sformatf("%0d", $urandom_range(0, 99))};
					default: body = $sformatf("@%0d", ($urandom_range(0, 3) == 0) ?
						$urandom_range(32768, 9999999) : $urandom_range(0, 32767));
				endcase
				if ($urandom_range(0, 4) == 0)
					body = {body, " ", one_of("x7;")};
				body = {blank(), body};
			end
			13, 14: begin
				body = {"(", one_of("LEX"), one_of("OND1")};
				if ($urandom_range(0, 4) != 0)
					body = {body, ")"};
				if ($urandom_range(0, 5) == 0)
					body = {body, one_of("x)")};
				body = {blank(), spread(body), blank()};
			end
			15: body = {blank(), ($urandom_range(0, 1) != 0) ? "// note" : ""};
			default: begin
				// raw bytes, half of them from the mnemonic alphabet
				n = $urandom_range(0, 8);
				repeat (n) begin
					if ($urandom_range(0, 1) != 0) begin
						pick = one_of("AMD01=;!-+&|@()/ J");
						send_item(KIND_CHAR, pick[0]);
					end else
						send_item(KIND_CHAR, char_t'($urandom_range(0, 255)));
				end
				send_item(KIND_EOL, char_t'($urandom));
				return;
			end
		endcase
		case ($urandom_range(0, 9))
			0:       tail = " // done";
			1:       tail = "/";
			2:       tail = "\r";
			3:       tail = "\r\n";
			default: tail = "";
		endcase
		send_line({body, tail});
	endtask

	initial begin
		int  start;
		bit  paused;
		string body;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines, then a line of extreme bytes
		foreach (directed_lines[i])
			send_line(directed_lines[i]);
		send_item(KIND_CHAR, 8'h00);
		send_item(KIND_CHAR, 8'hFF);
		send_item(KIND_EOL, 8'h00);
		drain();

		// every comp under a long output hold, requests offered back to back
		tx_gaps  = 1'b0;
		hold_req = 1'b1;
		foreach (comp_ops[i]) begin
			if (i % 8 == 7)
				body = {comp_ops[i], ";", jump_ops[i % 7]};
			else begin
				body = {dest_forms[i % 7], "=", comp_ops[i]};
				if (i % 3 == 0)
					body = {body, ";", jump_ops[i % 7]};
			end
			send_line(body);
		end
		drain();
		tx_gaps = 1'b1;

		// random lines with idling on both sides, one pause half way
		start  = sent;
		paused = 1'b0;
		while (sent - start < RANDOM_ITEMS - CALM_ITEMS) begin
			random_line();
			if (!paused && sent - start >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				drain();
			end
		end

		// last stretch at full rate
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		while (sent - start < RANDOM_ITEMS)
			random_line();
		drain();
		repeat (8) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/hile_pkg.sv
rtl/core/hile_line.sv
rtl/core/hile_encode.sv
rtl/core/hack_instruction_line_encoder.sv
rtl/core/hile_checker.sv
test/line_encode_checker.sv
test/testbench.sv
